// ===== rtl/lgrs_pkg.sv =====
// lgrs_pkg: shared widths, phase codes, reply constants and helpers
// for the link gate reply sequencer; no dependencies
package lgrs_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned PhaseW = 4;
  localparam int unsigned RiseW  = 8;
  localparam int unsigned FallW  = 10;
  localparam int unsigned FlavW  = 2;
  localparam int unsigned CfgIdxW = 1;

  typedef logic [WordW-1:0]  word_t;
  typedef logic [PhaseW-1:0] phase_t;
  typedef logic [FlavW-1:0]  flavor_t;

  // phase codes
  localparam phase_t PH_SYNC   = 4'd0;
  localparam phase_t PH_CMD    = 4'd1;
  localparam phase_t PH_FILL_A = 4'd2;
  localparam phase_t PH_FILL_B = 4'd3;
  localparam phase_t PH_RISE   = 4'd4;
  localparam phase_t PH_FALL   = 4'd5;
  localparam phase_t PH_ID     = 4'd6;
  localparam phase_t PH_ZERO_A = 4'd7;
  localparam phase_t PH_ZERO_B = 4'd8;
  localparam phase_t PH_END    = 4'd9;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_GATE_FLAVOR = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_CHIP_ID     = 1'd1;

  // flavour codes
  localparam flavor_t FLAV_CHIP     = 2'd0;
  localparam flavor_t FLAV_PROGRESS = 2'd1;
  localparam flavor_t FLAV_BEAST    = 2'd2;
  localparam flavor_t FLAV_BEAST_US = 2'd3;

  localparam word_t SYNC_WORD   = 16'h8FFF;
  localparam word_t FILL_WORD   = 16'hFFFF;
  localparam word_t ZERO_WORD   = 16'h0000;
  localparam logic [WordW-FallW-1:0] FALL_TOP = '1;

  localparam logic [RiseW-1:0] RISE_RESET = 8'hFE;
  localparam logic [FallW-1:0] FALL_RESET = 10'h3FE;
  localparam logic [RiseW-1:0] RISE_STEP  = 8'd3;
  localparam logic [FallW-1:0] FALL_STEP  = 10'd3;

  function automatic word_t ok_code(input flavor_t f);
    word_t c;
    case (f)
      FLAV_CHIP:     c = 16'hFFC6;
      FLAV_PROGRESS: c = 16'hFFC7;
      FLAV_BEAST:    c = 16'hFFC4;
      FLAV_BEAST_US: c = 16'hFF00;
      default:       c = 16'hFFC6;
    endcase
    return c;
  endfunction

  function automatic logic is_resync(input word_t w);
    logic r;
    case (w) inside
      16'hA380, 16'hA390, 16'hA3A0, 16'hA3B0,
      16'hA3C0, 16'hA3D0, 16'hA6C0: r = 1'b1;
      default:                      r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/lgrs_cmd_if.sv =====
// lgrs_cmd_if: valid/ready channel carrying one host command word
// depends on lgrs_pkg
interface lgrs_cmd_if import lgrs_pkg::*; (input logic clk);
  logic  valid;
  logic  ready;
  word_t command_word;

  modport source (output valid, output command_word, input ready);
  modport sink (input valid, input command_word, output ready);
endinterface

// ===== rtl/lgrs_rsp_if.sv =====
// lgrs_rsp_if: valid/ready channel carrying the echoed command and reply
// depends on lgrs_pkg
interface lgrs_rsp_if import lgrs_pkg::*; (input logic clk);
  logic  valid;
  logic  ready;
  word_t echoed_command;
  word_t reply_word;

  modport source (output valid, output echoed_command, output reply_word, input ready);
  modport sink (input valid, input echoed_command, input reply_word, output ready);
endinterface

// ===== rtl/lgrs_phase_seq.sv =====
// lgrs_phase_seq: ten-phase reply sequencer with its counters
// depends on lgrs_pkg; state advances once per item taken
module lgrs_phase_seq import lgrs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  word_t   word,
  input  flavor_t gate_flavor,
  input  word_t   chip_id,
  output word_t   reply
);

  phase_t             phase, phase_next, eff;
  logic [RiseW-1:0]   rising_counter, rising_counter_next;
  logic [FallW-1:0]   falling_counter_low, falling_counter_low_next;
  word_t              ok;

  always_comb begin
    ok = ok_code(gate_flavor);
    eff = phase;
    if (phase != PH_CMD && is_resync(word)) begin
      eff = PH_SYNC;
    end
    reply = ok;
    phase_next = PH_SYNC;
    rising_counter_next = rising_counter;
    falling_counter_low_next = falling_counter_low;
    unique case (eff)
      PH_CMD: begin
        phase_next = PH_FILL_A;
      end
      PH_FILL_A: begin
        reply = FILL_WORD;
        phase_next = PH_FILL_B;
      end
      PH_FILL_B: begin
        reply = FILL_WORD;
        phase_next = PH_RISE;
      end
      PH_RISE: begin
        reply = {{(WordW-RiseW){1'b0}}, rising_counter};
        rising_counter_next = rising_counter + RISE_STEP;
        phase_next = PH_FALL;
      end
      PH_FALL: begin
        reply = {FALL_TOP, falling_counter_low};
        falling_counter_low_next = falling_counter_low - FALL_STEP;
        phase_next = PH_ID;
      end
      PH_ID: begin
        reply = chip_id;
        phase_next = PH_ZERO_A;
      end
      PH_ZERO_A: begin
        reply = ZERO_WORD;
        phase_next = PH_ZERO_B;
      end
      PH_ZERO_B: begin
        reply = ZERO_WORD;
        phase_next = PH_END;
      end
      PH_END: begin
        phase_next = PH_CMD;
      end
      default: begin
        // sync, and unreachable codes behave as sync
        phase_next = (word == SYNC_WORD) ? PH_CMD : PH_SYNC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SYNC;
      rising_counter <= RISE_RESET;
      falling_counter_low <= FALL_RESET;
    end else if (advance) begin
      phase <= phase_next;
      rising_counter <= rising_counter_next;
      falling_counter_low <= falling_counter_low_next;
    end
  end

endmodule

// ===== rtl/link_gate_reply_sequencer_top.sv =====
// link_gate_reply_sequencer_top: peripheral side of a multiplayer link gate
// reply item registered after its command item is taken; one item per cycle while the receiver is ready
// input register, sequencer logic, result register; ready chains through both stages
// synchronous active-high reset: sync phase, counters 0xFE / 0x3FE, valid flags and config registers zero
// depends on lgrs_pkg, lgrs_cmd_if, lgrs_rsp_if, lgrs_phase_seq
module link_gate_reply_sequencer_top import lgrs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  lgrs_cmd_if.sink           cmd,
  lgrs_rsp_if.source         rsp,
  input  logic               cfg_wr_en,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  word_t              cfg_data
);

  flavor_t gate_flavor;
  word_t   chip_id;

  logic  in_valid;
  word_t in_word;
  logic  out_valid;
  word_t out_echo;
  word_t out_reply;
  word_t reply;
  logic  move;
  logic  take;

  assign move = in_valid && (!out_valid || rsp.ready);
  assign take = cmd.valid && cmd.ready;
  assign cmd.ready = !in_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_flavor <= FLAV_CHIP;
      chip_id <= ZERO_WORD;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_GATE_FLAVOR: gate_flavor <= cfg_data[FlavW-1:0];
        CFG_CHIP_ID:     chip_id <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (move) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_word <= cmd.command_word;
    end
  end

  lgrs_phase_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .advance     (move),
    .word        (in_word),
    .gate_flavor (gate_flavor),
    .chip_id     (chip_id),
    .reply       (reply)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_echo <= in_word;
      out_reply <= reply;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.echoed_command = out_echo;
  assign rsp.reply_word = out_reply;

endmodule

// ===== test/tb_link_gate_reply_sequencer_top.sv =====
// tb_link_gate_reply_sequencer_top: self-checking testbench for the link gate reply sequencer
// drives command items, predicts each reply, checks echoed command and reply per item
// depends on lgrs_pkg, lgrs_cmd_if, lgrs_rsp_if, link_gate_reply_sequencer_top
module tb_link_gate_reply_sequencer_top import lgrs_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1400;

  localparam word_t OK_CODES [4] = '{16'hFFC6, 16'hFFC7, 16'hFFC4, 16'hFF00};
  localparam word_t RESYNC_WORDS [7] = '{16'hA380, 16'hA390, 16'hA3A0, 16'hA3B0,
                                         16'hA3C0, 16'hA3D0, 16'hA6C0};

  typedef struct packed {
    word_t echo;
    word_t reply;
  } gate_reply_t;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [CfgIdxW-1:0] cfg_index;
  word_t              cfg_data;

  lgrs_cmd_if cmd_ch (clk);
  lgrs_rsp_if rsp_ch (clk);

  link_gate_reply_sequencer_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // sequencer mirror
  phase_t           seq_phase;
  logic [RiseW-1:0] rise_count;
  logic [FallW-1:0] fall_low;
  flavor_t          cur_flavor;
  word_t            cur_chip_id;

  gate_reply_t pending_replies [$];

  int  fail_count;
  int  cycle_count;
  int  items_sent;
  int  random_sent;
  int  rounds_done;
  int  resyncs_seen;
  int  fall_wraps;
  int  settings_run;
  int  stall_left;
  int  hold_cycles;
  bit  no_idle;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items outstanding", cycle_count,
               pending_replies.size());
      $display("tb_link_gate_reply_sequencer_top: FAIL");
      $finish;
    end
  end

  function automatic bit is_resync_word(input word_t w);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < 7; i++) begin
      if (RESYNC_WORDS[i] == w) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic gate_reply_t gate_reply_for(input word_t w);
    gate_reply_t r;
    phase_t      p;
    word_t       ok;
    ok = OK_CODES[cur_flavor];
    p = (seq_phase > PH_END) ? PH_SYNC : seq_phase;
    if (p != PH_CMD && is_resync_word(w)) begin
      p = PH_SYNC;
      resyncs_seen++;
    end
    r.echo = w;
    case (p)
      PH_CMD: begin
        r.reply = ok;
        seq_phase = PH_FILL_A;
      end
      PH_FILL_A, PH_FILL_B: begin
        r.reply = FILL_WORD;
        seq_phase = p + 1'b1;
      end
      PH_RISE: begin
        r.reply = {{(WordW-RiseW){1'b0}}, rise_count};
        rise_count = rise_count + RISE_STEP;
        seq_phase = PH_FALL;
      end
      PH_FALL: begin
        r.reply = {FALL_TOP, fall_low};
        if (fall_low < FALL_STEP) fall_wraps++;
        fall_low = fall_low - FALL_STEP;
        seq_phase = PH_ID;
      end
      PH_ID: begin
        r.reply = cur_chip_id;
        seq_phase = PH_ZERO_A;
      end
      PH_ZERO_A, PH_ZERO_B: begin
        r.reply = ZERO_WORD;
        seq_phase = p + 1'b1;
      end
      PH_END: begin
        r.reply = ok;
        seq_phase = PH_CMD;
        rounds_done++;
      end
      default: begin
        r.reply = ok;
        seq_phase = (w == SYNC_WORD) ? PH_CMD : PH_SYNC;
      end
    endcase
    return r;
  endfunction

  function automatic word_t pick_command(input int resync_permille);
    int roll;
    roll = $urandom_range(0, 999);
    if (roll < resync_permille) return RESYNC_WORDS[$urandom_range(0, 6)];
    if (roll < resync_permille + 20) return SYNC_WORD;
    return word_t'($urandom_range(0, 65535));
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    fail_count++;
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
  endtask

  task automatic send_command(input word_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.command_word <= w;
    do @(posedge clk); while (!cmd_ch.ready);
    pending_replies.push_back(gate_reply_for(w));
    items_sent++;
  endtask

  task automatic wait_drained;
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input word_t data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_GATE_FLAVOR) cur_flavor = data[FlavW-1:0];
    else cur_chip_id = data;
  endtask

  // receiver: per-item stall plus an optional long hold
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    gate_reply_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("item with nothing pending, echo", rsp_ch.echoed_command, '0);
      end else begin
        want = pending_replies.pop_front();
        if (rsp_ch.echoed_command !== want.echo)
          report_mismatch("echoed_command", rsp_ch.echoed_command, want.echo);
        if (rsp_ch.reply_word !== want.reply)
          report_mismatch("reply_word", rsp_ch.reply_word, want.reply);
      end
      stall_left = no_idle ? 0 : $urandom_range(0, 5);
    end
  end

  // sync miss, sync word, then one full round with edge values
  task automatic test_reset_round;
    send_command(16'h0000);
    send_command(16'hFFFF);
    send_command(SYNC_WORD);
    send_command(16'h0001);
    send_command(16'h8000);
    send_command(16'h7FFF);
    send_command(16'h5555);
    send_command(16'hAAAA);
    send_command(16'h8FFE);
    send_command(16'h0F0F);
    send_command(16'hF0F0);
    send_command(16'hA381);
    wait_drained();
  endtask

  // resync word ignored in command phase, honoured elsewhere
  task automatic test_resync_cases;
    send_command(RESYNC_WORDS[0]);
    send_command(RESYNC_WORDS[6]);
    send_command(RESYNC_WORDS[5]);
    send_command(SYNC_WORD);
    wait_drained();
  endtask

  task automatic test_flavours;
    flavor_t f;
    for (int i = 0; i < 4; i++) begin
      f = flavor_t'(i);
      write_reg(CFG_GATE_FLAVOR, word_t'(f));
      send_command(RESYNC_WORDS[3]);
      wait_drained();
    end
  endtask

  task automatic test_backpressure;
    @(posedge clk);
    hold_cycles = 60;
    no_idle = 1'b1;
    send_command(SYNC_WORD);
    repeat (27) send_command(pick_command(0));
    no_idle = 1'b0;
    wait_drained();
  endtask

  task automatic run_sessions(input int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        repeat ($urandom_range(0, 2)) begin
          send_command(pick_command(100));
          sent++;
        end
        send_command(SYNC_WORD);
        sent++;
        repeat ($urandom_range(1, 40) * 9) begin
          send_command(pick_command(3));
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_command(pick_command(200));
          sent++;
        end
      end
    end
    random_sent += sent;
  endtask

  task automatic test_random_traffic;
    while (random_sent < RANDOM_ITEMS) begin
      case (settings_run)
        0: begin
          write_reg(CFG_GATE_FLAVOR, word_t'(FLAV_CHIP));
          write_reg(CFG_CHIP_ID, 16'h0000);
        end
        1: begin
          write_reg(CFG_GATE_FLAVOR, 16'hFFFF);
          write_reg(CFG_CHIP_ID, 16'hFFFF);
        end
        default: begin
          write_reg(CFG_GATE_FLAVOR, word_t'($urandom_range(0, 65535)));
          write_reg(CFG_CHIP_ID, word_t'($urandom_range(0, 65535)));
        end
      endcase
      no_idle = (settings_run % 3 == 2);
      run_sessions(250);
      no_idle = 1'b0;
      wait_drained();
      settings_run++;
    end
  endtask

  initial begin
    rst                 = 1'b1;
    cmd_ch.valid        = 1'b0;
    cmd_ch.command_word = '0;
    cfg_wr_en           = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    seq_phase           = PH_SYNC;
    rise_count          = RISE_RESET;
    fall_low            = FALL_RESET;
    cur_flavor          = FLAV_CHIP;
    cur_chip_id         = ZERO_WORD;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_round();
    test_resync_cases();
    test_flavours();
    test_backpressure();
    test_random_traffic();
    wait_drained();

    $display("%0d command items over %0d register settings, %0d full rounds",
             items_sent, settings_run, rounds_done);
    $display("%0d resyncs taken, falling counter wrapped %0d times, %0d mismatches",
             resyncs_seen, fall_wraps, fail_count);
    if (fail_count == 0) begin
      $display("tb_link_gate_reply_sequencer_top: PASS");
    end else begin
      $display("tb_link_gate_reply_sequencer_top: FAIL");
    end
    $finish;
  end

endmodule
